FILE: design/bdph_pkg.sv
// Shared types and constants for the three-button debouncer with long-press detection.
// It depends on nothing. The lane, output stage and top level all use it.
`timescale 1ns / 1ps

package bdph_pkg;

    // Number of debounced buttons (up, down, start).
    localparam int BTN_COUNT = 3;

    localparam int PORT_W    = 8;
    localparam int COUNT_W   = 8;
    localparam int LIMIT_W   = 8;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL = 1'd1;

    // Values of the configuration registers after reset.
    localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RST    = 8'd100;
    localparam logic               PRESSED_LEVEL_RST = 1'b0;

    // Port bit that carries each button: up, down, start.
    localparam logic [2:0] PORT_BIT [BTN_COUNT] = '{3'd4, 3'd5, 3'd2};

    // Next state of one button lane, which is also what the result shows.
    typedef struct packed {
        logic               short_flag;
        logic               long_flag;
        logic [COUNT_W-1:0] count;
    } t_lane_res;

endpackage

FILE: design/bdph_lane.sv
// One button lane: two-sample debounce, hold counter, short and long flags.
// It depends on bdph_pkg for widths and the lane result type.
`timescale 1ns / 1ps

module bdph_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_sample,
    input  logic                             i_pressed_level,
    input  logic [bdph_pkg::LIMIT_W-1:0]     i_hold_limit,
    output bdph_pkg::t_lane_res              o_next
);

    logic                           r_newer;
    logic                           r_short;
    logic                           r_long;
    logic [bdph_pkg::COUNT_W-1:0]   r_count;
    logic                           n_short;
    logic                           n_long;
    logic [bdph_pkg::COUNT_W-1:0]   n_count;
    logic                           w_stable;

    // The level is stable when the new sample matches the latest stored one.
    assign w_stable = (i_sample == r_newer);

    // Next lane state for the incoming sample.
    always_comb begin
        n_short = r_short;
        n_long  = r_long;
        n_count = r_count;
        if (w_stable) begin
            if (i_sample == i_pressed_level) begin
                if (r_count < i_hold_limit) begin
                    n_count = r_count + 1'b1;
                end else begin
                    n_long = 1'b1;
                end
            end else begin
                n_short = (r_count != '0) && !r_long;
                n_count = '0;
                n_long  = 1'b0;
            end
        end
    end

    assign o_next = '{short_flag: n_short, long_flag: n_long, count: n_count};

    // Lane state advances on every accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newer <= 1'b0;
            r_short <= 1'b0;
            r_long  <= 1'b0;
            r_count <= '0;
        end else if (i_accept) begin
            r_newer <= i_sample;
            r_short <= n_short;
            r_long  <= n_long;
            r_count <= n_count;
        end
    end

    // A stable released tick always leaves the counter and long flag cleared.
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && w_stable && (i_sample != i_pressed_level)
        |=> (r_count == '0) && !r_long)
        else $error("hold counter or long flag survived a release");

    // A short press can only be recorded when the long flag is clear.
    a_short_long_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && w_stable && (i_sample != i_pressed_level) && r_long
        |=> !r_short)
        else $error("short press flagged after a long hold");

endmodule

FILE: design/bdph_merge.sv
// Merging stage: packs the lane results into one result word and holds it
// in an output register backed by a skid register. Depends on bdph_pkg.
`timescale 1ns / 1ps

module bdph_merge (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_accept,
    input  bdph_pkg::t_lane_res [bdph_pkg::BTN_COUNT-1:0] i_lanes,
    output logic                                        o_in_ready,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic [bdph_pkg::OUT_W-1:0]                  o_data
);

    logic [bdph_pkg::OUT_W-1:0] w_word;
    logic [bdph_pkg::OUT_W-1:0] r_out;
    logic [bdph_pkg::OUT_W-1:0] r_skid;
    logic                       r_out_valid;
    logic                       r_skid_valid;
    logic                       w_take;

    // Result word: short flags, long flags, then the three hold counters.
    assign w_word = {2'b00,
                     i_lanes[2].count, i_lanes[1].count, i_lanes[0].count,
                     i_lanes[2].long_flag, i_lanes[1].long_flag, i_lanes[0].long_flag,
                     i_lanes[2].short_flag, i_lanes[1].short_flag, i_lanes[0].short_flag};

    assign w_take     = r_out_valid && i_ready;
    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    // Output register with skid: a new result goes to the skid only when
    // the output register is full and not being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_take) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_accept) begin
                if (!r_out_valid || w_take) begin
                    r_out       <= w_word;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= w_word;
                    r_skid_valid <= 1'b1;
                end
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The skid never holds a result while the output register is empty.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full with empty output register");

    // A transfer accepted into a stalled full output must land in the skid.
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_out_valid && !i_ready |=> r_skid_valid)
        else $error("accepted result lost while output stalled");

endmodule

FILE: design/button_debounce_press_hold.sv
// Top level of the three-button debouncer with short-press and long-hold flags.
// Depends on bdph_pkg, bdph_lane (one per button) and bdph_merge.
//
//  channel  direction  handshake                       payload
//  s_axis   in         s_axis_tvalid / s_axis_tready   tdata[7:0] port_byte
//  m_axis   out        m_axis_tvalid / m_axis_tready   tdata[29:0] result fields
//  cfg      in         i_cfg_we                        i_cfg_addr, i_cfg_wdata
//
// One tick transfer is accepted per clock while s_axis_tready is high.
// All lanes update in the accepting cycle; the merge stage registers the result.
// The output and skid registers hold up to two results while m_axis stalls.
// s_axis_tready is low while the skid is full, including the cycle it drains.
// Synchronous active-low reset clears all lane state and restores the registers.
`timescale 1ns / 1ps

module button_debounce_press_hold (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bdph_pkg::PORT_W-1:0]      s_axis_tdata,   // [7:0] port_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] short_press, [5:3] long_hold, [13:6] hold_count_up,
    // [21:14] hold_count_down, [29:22] hold_count_start, [31:30] zero
    output logic [bdph_pkg::OUT_W-1:0]       m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [bdph_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [bdph_pkg::CFG_DAT_W-1:0]   i_cfg_wdata
);

    logic [bdph_pkg::LIMIT_W-1:0]                 r_hold_limit;
    logic                                         r_pressed_level;
    logic                                         w_accept;
    bdph_pkg::t_lane_res [bdph_pkg::BTN_COUNT-1:0] w_lanes;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_limit    <= bdph_pkg::HOLD_LIMIT_RST;
            r_pressed_level <= bdph_pkg::PRESSED_LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bdph_pkg::CFG_HOLD_LIMIT:    r_hold_limit    <= i_cfg_wdata;
                bdph_pkg::CFG_PRESSED_LEVEL: r_pressed_level <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // One lane per button, each fed from its fixed port bit.
    for (genvar b = 0; b < bdph_pkg::BTN_COUNT; b++) begin : g_lane
        bdph_lane u_lane (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_accept        (w_accept),
            .i_sample        (s_axis_tdata[bdph_pkg::PORT_BIT[b]]),
            .i_pressed_level (r_pressed_level),
            .i_hold_limit    (r_hold_limit),
            .o_next          (w_lanes[b])
        );
    end

    // Merge the lane results into the output stream.
    bdph_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_lanes    (w_lanes),
        .o_in_ready (s_axis_tready),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

endmodule
